[hw/rtl/mcm_pkg.sv]
package mcm_pkg;

  localparam int ROM_ADDR_W = 21;

  localparam logic [1:0] FUNC_CPU_WRITE = 2'd0;
  localparam logic [1:0] FUNC_CPU_READ  = 2'd1;
  localparam logic [1:0] FUNC_PRG_XLATE = 2'd2;
  localparam logic [1:0] FUNC_CHR_XLATE = 2'd3;

  localparam logic [1:0] CFG_PRG_BANKS_LOG2 = 2'd0;
  localparam logic [1:0] CFG_CHR_BANKS_LOG2 = 2'd1;
  localparam logic [1:0] CFG_DIP_SWITCH     = 2'd2;

  localparam logic [1:0] OUTER_MODE_REG = 2'd0;
  localparam logic [1:0] OUTER_PRG_REG  = 2'd1;
  localparam logic [1:0] OUTER_CHR_REG  = 2'd2;

  localparam logic [3:0]  OUTER_PAGE       = 4'h5;
  localparam logic [15:0] MMC3_DECODE_MASK = 16'hE001;
  localparam logic [15:0] MMC3_BANK_SELECT = 16'h8000;
  localparam logic [15:0] MMC3_BANK_DATA   = 16'h8001;

  typedef struct packed {
    logic [7:0]       outer_mode;
    logic [5:0]       prg_outer_base;
    logic [7:0]       chr_outer_base;
    logic [7:0]       bank_select;
    logic [1:0]       cnrom_latch;
    logic [7:0][7:0]  bank_regs;
    logic [2:0]       prg_banks_log2;
    logic [3:0]       chr_banks_log2;
    logic [1:0]       dip_switch;
  } mcm_state_t;

endpackage

[hw/rtl/mcm_regs.sv]
module mcm_regs
  import mcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [15:0] wr_addr,
  input  logic [7:0]  wr_data,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  output mcm_state_t  st
);

  logic [7:0]      outer_mode_r, outer_mode_nxt;
  logic [5:0]      prg_outer_base_r, prg_outer_base_nxt;
  logic [7:0]      chr_outer_base_r, chr_outer_base_nxt;
  logic [7:0]      bank_select_r, bank_select_nxt;
  logic [1:0]      cnrom_latch_r, cnrom_latch_nxt;
  logic [7:0][7:0] bank_regs_r, bank_regs_nxt;
  logic [2:0]      prg_banks_log2_r, prg_banks_log2_nxt;
  logic [3:0]      chr_banks_log2_r, chr_banks_log2_nxt;
  logic [1:0]      dip_switch_r, dip_switch_nxt;

  always_comb begin
    outer_mode_nxt     = outer_mode_r;
    prg_outer_base_nxt = prg_outer_base_r;
    chr_outer_base_nxt = chr_outer_base_r;
    bank_select_nxt    = bank_select_r;
    cnrom_latch_nxt    = cnrom_latch_r;
    bank_regs_nxt      = bank_regs_r;
    if (wr_en) begin
      if (!wr_addr[15]) begin
        if (wr_addr[15:12] == OUTER_PAGE && !outer_mode_r[7]) begin
          unique case (wr_addr[1:0])
            OUTER_MODE_REG: outer_mode_nxt     = wr_data;
            OUTER_PRG_REG:  prg_outer_base_nxt = wr_data[5:0];
            OUTER_CHR_REG:  chr_outer_base_nxt = wr_data;
            default: ;
          endcase
        end
      end else begin
        if (outer_mode_r[2:1] == 2'b11) cnrom_latch_nxt = wr_data[1:0];
        if ((wr_addr & MMC3_DECODE_MASK) == MMC3_BANK_SELECT)
          bank_select_nxt = wr_data;
        else if ((wr_addr & MMC3_DECODE_MASK) == MMC3_BANK_DATA)
          bank_regs_nxt[bank_select_r[2:0]] = wr_data;
      end
    end
  end

  always_comb begin
    prg_banks_log2_nxt = prg_banks_log2_r;
    chr_banks_log2_nxt = chr_banks_log2_r;
    dip_switch_nxt     = dip_switch_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRG_BANKS_LOG2: prg_banks_log2_nxt = cfg_wdata[2:0];
        CFG_CHR_BANKS_LOG2: chr_banks_log2_nxt = cfg_wdata;
        CFG_DIP_SWITCH:     dip_switch_nxt     = cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_mode_r     <= '0;
      prg_outer_base_r <= '0;
      chr_outer_base_r <= '0;
      bank_select_r    <= '0;
      cnrom_latch_r    <= '0;
      bank_regs_r      <= {8'd0, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};
      prg_banks_log2_r <= 3'd7;
      chr_banks_log2_r <= 4'd11;
      dip_switch_r     <= '0;
    end else begin
      outer_mode_r     <= outer_mode_nxt;
      prg_outer_base_r <= prg_outer_base_nxt;
      chr_outer_base_r <= chr_outer_base_nxt;
      bank_select_r    <= bank_select_nxt;
      cnrom_latch_r    <= cnrom_latch_nxt;
      bank_regs_r      <= bank_regs_nxt;
      prg_banks_log2_r <= prg_banks_log2_nxt;
      chr_banks_log2_r <= chr_banks_log2_nxt;
      dip_switch_r     <= dip_switch_nxt;
    end
  end

  always_comb begin
    st.outer_mode     = outer_mode_r;
    st.prg_outer_base = prg_outer_base_r;
    st.chr_outer_base = chr_outer_base_r;
    st.bank_select    = bank_select_r;
    st.cnrom_latch    = cnrom_latch_r;
    st.bank_regs      = bank_regs_r;
    st.prg_banks_log2 = prg_banks_log2_r;
    st.chr_banks_log2 = chr_banks_log2_r;
    st.dip_switch     = dip_switch_r;
  end

  // locked outer registers never move on a CPU write
  a_outer_lock: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && outer_mode_r[7] |=>
      $stable(outer_mode_r) && $stable(prg_outer_base_r) && $stable(chr_outer_base_r))
    else $error("outer register changed while locked");

  a_mmc3_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(bank_select_r) && $stable(bank_regs_r) && $stable(cnrom_latch_r))
    else $error("mapper register changed without a CPU write");

endmodule

[hw/rtl/mcm_xlate.sv]
module mcm_xlate
  import mcm_pkg::*;
(
  input  mcm_state_t             st,
  input  logic [1:0]             func,
  input  logic [15:0]            bus_address,
  input  logic [7:0]             open_bus,
  output logic [7:0]             read_data,
  output logic [ROM_ADDR_W-1:0]  rom_address
);

  logic [4:0]  prg_mask;
  logic [6:0]  prg_outer_bank;
  logic [1:0]  prg_slot;
  logic [7:0]  prg_inner;
  logic [6:0]  prg_cnt0;
  logic [5:0]  prg_cnt1;
  logic [4:0]  prg_cnt2;
  logic [6:0]  prg_bank8k;
  logic [19:0] prg_addr;

  logic [2:0]  chr_slot;
  logic [2:0]  chr_idx;
  logic [7:0]  chr_inner;
  logic [7:0]  chr_mask;
  logic [1:0]  cn_mask;
  logic [7:0]  cn_blk;
  logic [10:0] chr_bank;
  logic [10:0] chr_cnt;
  logic [20:0] chr_addr;

  always_comb begin
    prg_mask = st.outer_mode[1] ? 5'h0F : 5'h1F;
    prg_outer_bank = {st.prg_outer_base, 1'b0} & ~{2'b00, prg_mask};
    prg_slot = bus_address[14:13] ^ {st.bank_select[6], 1'b0};
    case (prg_slot)
      2'd0:    prg_inner = st.bank_regs[6];
      2'd1:    prg_inner = st.bank_regs[7];
      2'd2:    prg_inner = 8'hFE;
      default: prg_inner = 8'hFF;
    endcase
    prg_cnt0 = ~(7'h7F << st.prg_banks_log2);
    prg_cnt1 = (st.prg_banks_log2 <= 3'd1) ? 6'd0 :
               ~(6'h3F << (st.prg_banks_log2 - 3'd1));
    prg_cnt2 = (st.prg_banks_log2 <= 3'd2) ? 5'd0 :
               ~(5'h1F << (st.prg_banks_log2 - 3'd2));
    prg_bank8k = (prg_outer_bank | {2'b00, prg_inner[4:0] & prg_mask}) & prg_cnt0;
    if (!st.outer_mode[2])
      prg_addr = {prg_bank8k, bus_address[12:0]};
    else if (st.outer_mode[1:0] == 2'b00)
      prg_addr = {st.prg_outer_base & prg_cnt1, bus_address[13:0]};
    else
      prg_addr = {st.prg_outer_base[5:1] & prg_cnt2, bus_address[14:0]};
  end

  always_comb begin
    chr_slot = bus_address[12:10];
    chr_idx  = chr_slot ^ {st.bank_select[7], 2'b00};
    case (chr_idx)
      3'd0:    chr_inner = {st.bank_regs[0][7:1], 1'b0};
      3'd1:    chr_inner = {st.bank_regs[0][7:1], 1'b1};
      3'd2:    chr_inner = {st.bank_regs[1][7:1], 1'b0};
      3'd3:    chr_inner = {st.bank_regs[1][7:1], 1'b1};
      default: chr_inner = st.bank_regs[chr_idx - 3'd2];
    endcase
    chr_mask = st.outer_mode[0] ? 8'h7F : 8'hFF;
    cn_mask  = st.outer_mode[0] ? 2'b11 : 2'b01;
    cn_blk   = {st.chr_outer_base[7:2],
                (st.chr_outer_base[1:0] & ~cn_mask) | (st.cnrom_latch & cn_mask)};
    if (!st.outer_mode[2])
      chr_bank = ({st.chr_outer_base, 3'b000} & ~{3'b000, chr_mask})
               | {3'b000, chr_inner & chr_mask};
    else if (st.outer_mode[1:0] != 2'b11 && !(st.outer_mode[1] && !st.outer_mode[0]))
      chr_bank = {st.chr_outer_base, chr_slot};
    else
      chr_bank = {cn_blk, chr_slot};
    chr_cnt  = ~(11'h7FF << st.chr_banks_log2);
    chr_addr = {chr_bank & chr_cnt, bus_address[9:0]};
  end

  always_comb begin
    read_data   = '0;
    rom_address = '0;
    case (func)
      FUNC_CPU_READ: begin
        if (bus_address[15:12] == OUTER_PAGE)
          read_data = {open_bus[7:2], st.dip_switch};
        else
          read_data = open_bus;
      end
      FUNC_PRG_XLATE: rom_address = ROM_ADDR_W'(prg_addr);
      FUNC_CHR_XLATE: rom_address = ROM_ADDR_W'(chr_addr);
      default: ;
    endcase
  end

endmodule

[hw/rtl/multicart_bank_mapper.sv]
// Multicart bank mapper: CPU write/read and PRG/CHR address translation.
// The start transfer passes through the input register, then the result register,
// to the result strobe. Throughput: one item per clock, busy is never raised.
// Receiver cannot stall; every result is shown for one cycle on out_valid.
// Synchronous active-low reset restores outer/MMC3 state and config defaults.
module multicart_bank_mapper
  import mcm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_func,
  input  logic [15:0]            in_bus_address,
  input  logic [7:0]             in_write_data,
  input  logic [7:0]             in_open_bus,
  output logic                   out_valid,
  output logic [7:0]             out_read_data,
  output logic [ROM_ADDR_W-1:0]  out_rom_address,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_wdata
);

  logic                  in_valid_r;
  logic [1:0]            in_func_r;
  logic [15:0]           in_addr_r;
  logic [7:0]            in_wdata_r;
  logic [7:0]            in_obus_r;

  logic                  out_valid_r;
  logic [7:0]            out_rdata_r;
  logic [ROM_ADDR_W-1:0] out_raddr_r;

  mcm_state_t            st;
  logic [7:0]            rdata_nxt;
  logic [ROM_ADDR_W-1:0] raddr_nxt;
  logic                  wr_en;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign wr_en     = in_valid_r && (in_func_r == FUNC_CPU_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_func_r  <= in_func;
      in_addr_r  <= in_bus_address;
      in_wdata_r <= in_write_data;
      in_obus_r  <= in_open_bus;
    end
    if (in_valid_r) begin
      out_rdata_r <= rdata_nxt;
      out_raddr_r <= raddr_nxt;
    end
  end

  mcm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (in_addr_r),
    .wr_data   (in_wdata_r),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .st        (st)
  );

  mcm_xlate u_xlate (
    .st          (st),
    .func        (in_func_r),
    .bus_address (in_addr_r),
    .open_bus    (in_obus_r),
    .read_data   (rdata_nxt),
    .rom_address (raddr_nxt)
  );

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_rdata_r;
  assign out_rom_address = out_raddr_r;

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result strobe without a start transfer two cycles earlier");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid && out_rom_address == '0 && out_read_data == '0)
    else $error("CPU write produced a non-zero result");

endmodule

[tb/bank_map_checker.sv]
module bank_map_checker
  import mcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            in_func,
  input  logic [15:0]           in_bus_address,
  input  logic [7:0]            in_write_data,
  input  logic [7:0]            in_open_bus,
  input  logic                  out_valid,
  input  logic [7:0]            out_read_data,
  input  logic [ROM_ADDR_W-1:0] out_rom_address,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [3:0]            cfg_wdata,
  output int                    pending,
  output int                    failures
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]            read_data;
    logic [ROM_ADDR_W-1:0] rom_address;
  } access_result_t;

  logic [7:0] outer_mode;
  logic [5:0] prg_outer;
  logic [7:0] chr_base;
  logic [7:0] bank_sel;
  logic [1:0] cnrom;
  logic [7:0] bank_regs [8];
  logic [2:0] prg_log2;
  logic [3:0] chr_log2;
  logic [1:0] dip;

  access_result_t expected_q [$];
  int fail_tally = 0;

  function automatic logic [31:0] bank_mask(input int unsigned log2v, input int unsigned less);
    if (log2v <= less) return 32'd0;
    return (32'd1 << (log2v - less)) - 32'd1;
  endfunction

  function automatic logic [31:0] prg_rom_address(input logic [15:0] addr);
    logic [31:0] mask;
    logic [31:0] base;
    logic [31:0] inner;
    logic [31:0] bank;
    logic [1:0]  slot;
    if (outer_mode[2:0] <= 3'd3) begin
      mask = outer_mode[1] ? 32'h0F : 32'h1F;
      base = {25'd0, prg_outer, 1'b0} & ~mask;
      slot = addr[14:13];
      if (bank_sel[6]) slot ^= 2'd2;
      case (slot)
        2'd0: inner = {24'd0, bank_regs[6]};
        2'd1: inner = {24'd0, bank_regs[7]};
        2'd2: inner = 32'hFE;
        default: inner = 32'hFF;
      endcase
      bank = (base | (inner & mask)) & bank_mask(32'(prg_log2), 32'd0);
      return (bank << 13) | {19'd0, addr[12:0]};
    end else if (outer_mode[2:0] == 3'd4) begin
      bank = {26'd0, prg_outer} & bank_mask(32'(prg_log2), 32'd1);
      return (bank << 14) | {18'd0, addr[13:0]};
    end
    bank = {27'd0, prg_outer[5:1]} & bank_mask(32'(prg_log2), 32'd2);
    return (bank << 15) | {17'd0, addr[14:0]};
  endfunction

  function automatic logic [31:0] chr_rom_address(input logic [15:0] addr);
    logic [31:0] mask;
    logic [31:0] base;
    logic [31:0] inner;
    logic [31:0] bank;
    logic [31:0] blk;
    logic [2:0]  slot;
    logic [2:0]  idx;
    slot = addr[12:10];
    if (outer_mode[2:0] <= 3'd3) begin
      mask = outer_mode[0] ? 32'h7F : 32'hFF;
      base = ({24'd0, chr_base} << 3) & ~mask;
      idx = slot;
      if (bank_sel[7]) idx ^= 3'd4;
      case (idx)
        3'd0: inner = {24'd0, bank_regs[0] & 8'hFE};
        3'd1: inner = {24'd0, bank_regs[0] | 8'h01};
        3'd2: inner = {24'd0, bank_regs[1] & 8'hFE};
        3'd3: inner = {24'd0, bank_regs[1] | 8'h01};
        default: inner = {24'd0, bank_regs[idx - 3'd2]};
      endcase
      bank = base | (inner & mask);
    end else if (outer_mode[2:0] <= 3'd5) begin
      bank = ({24'd0, chr_base} << 3) | {29'd0, slot};
    end else begin
      mask = outer_mode[0] ? 32'h03 : 32'h01;
      blk = ({24'd0, chr_base} & ~mask) | ({30'd0, cnrom} & mask);
      bank = (blk << 3) | {29'd0, slot};
    end
    bank &= bank_mask(32'(chr_log2), 32'd0);
    return (bank << 10) | {22'd0, addr[9:0]};
  endfunction

  function automatic void cpu_write(input logic [15:0] addr, input logic [7:0] val);
    if (!addr[15]) begin
      if (addr[15:12] == OUTER_PAGE && !outer_mode[7]) begin
        case (addr[1:0])
          OUTER_MODE_REG: outer_mode = val;
          OUTER_PRG_REG:  prg_outer = val[5:0];
          OUTER_CHR_REG:  chr_base = val;
          default: ;
        endcase
      end
    end else begin
      if (outer_mode[2:0] >= 3'd6) cnrom = val[1:0];
      case (addr & MMC3_DECODE_MASK)
        MMC3_BANK_SELECT: bank_sel = val;
        MMC3_BANK_DATA:   bank_regs[bank_sel[2:0]] = val;
        default: ;
      endcase
    end
  endfunction

  function automatic access_result_t apply_access(input logic [1:0] func,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] wdata,
                                                  input logic [7:0] obus);
    access_result_t res;
    logic [31:0] rom;
    res = '0;
    case (func)
      FUNC_CPU_WRITE: cpu_write(addr, wdata);
      FUNC_CPU_READ:  res.read_data = (addr[15:12] == OUTER_PAGE) ? {obus[7:2], dip} : obus;
      FUNC_PRG_XLATE: begin
        rom = prg_rom_address(addr);
        res.rom_address = rom[ROM_ADDR_W-1:0];
      end
      default: begin
        rom = chr_rom_address(addr);
        res.rom_address = rom[ROM_ADDR_W-1:0];
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      outer_mode = '0;
      prg_outer  = '0;
      chr_base   = '0;
      bank_sel   = '0;
      cnrom      = '0;
      bank_regs  = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd0};
      prg_log2   = 3'd7;
      chr_log2   = 4'd11;
      dip        = 2'd0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: read_data %0h rom_address %0h",
                 out_read_data, out_rom_address);
          fail_tally++;
        end else begin
          want = expected_q.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_read_data);
            fail_tally++;
          end
          if (out_rom_address !== want.rom_address) begin
            $error("rom_address: expected %0h, got %0h", want.rom_address, out_rom_address);
            fail_tally++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRG_BANKS_LOG2: prg_log2 = cfg_wdata[2:0];
          CFG_CHR_BANKS_LOG2: chr_log2 = cfg_wdata;
          CFG_DIP_SWITCH:     dip = cfg_wdata[1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_q.push_back(apply_access(in_func, in_bus_address, in_write_data, in_open_bus));
    end
    pending  <= expected_q.size();
    failures <= fail_tally;
  end

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mcm_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASES       = 8;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASE_ITEMS  = (RANDOM_ITEMS + PHASES - 2) / (PHASES - 1);
  localparam logic [1:0] OUTER_SPARE_REG = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_func = FUNC_CPU_READ;
  logic [15:0]           in_bus_address = '0;
  logic [7:0]            in_write_data = '0;
  logic [7:0]            in_open_bus = '0;
  logic                  out_valid;
  logic [7:0]            out_read_data;
  logic [ROM_ADDR_W-1:0] out_rom_address;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = CFG_PRG_BANKS_LOG2;
  logic [3:0]            cfg_wdata = '0;

  int pending;
  int failures;
  int idle_cycles = 0;
  bit steady = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  multicart_bank_mapper DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_bus_address  (in_bus_address),
    .in_write_data   (in_write_data),
    .in_open_bus     (in_open_bus),
    .out_valid       (out_valid),
    .out_read_data   (out_read_data),
    .out_rom_address (out_rom_address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  bank_map_checker u_map_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_bus_address  (in_bus_address),
    .in_write_data   (in_write_data),
    .in_open_bus     (in_open_bus),
    .out_valid       (out_valid),
    .out_read_data   (out_read_data),
    .out_rom_address (out_rom_address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .pending         (pending),
    .failures        (failures)
  );

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [15:0] outer_addr(input logic [1:0] sel);
    return {OUTER_PAGE, 10'h000, sel};
  endfunction

  task automatic send_access(input logic [1:0] func, input logic [15:0] addr,
                             input logic [7:0] wdata, input logic [7:0] obus);
    while (!steady && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_func        <= func;
    in_bus_address <= addr;
    in_write_data  <= wdata;
    in_open_bus    <= obus;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] value);
    while (!steady && $urandom_range(0, 99) < 18) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_banks(input int unsigned prg, input int unsigned chr, input int unsigned sw);
    write_reg(CFG_PRG_BANKS_LOG2, 4'(prg));
    write_reg(CFG_CHR_BANKS_LOG2, 4'(chr));
    write_reg(CFG_DIP_SWITCH, 4'(sw));
    cfg_valid <= 1'b0;
  endtask

  // stop sending and wait until every result is back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic random_access();
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  wdata;
    int unsigned pick;
    int unsigned kind;
    addr  = 16'($urandom);
    wdata = 8'($urandom);
    pick  = $urandom_range(0, 99);
    if (pick < 40) begin
      func = FUNC_CPU_WRITE;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        addr[15:12] = OUTER_PAGE;
        if (addr[1:0] == OUTER_MODE_REG) wdata[7] = 1'b0;
      end else if (kind < 8) begin
        addr[15]    = 1'b1;
        addr[14:13] = 2'b00;
      end
    end else if (pick < 50) begin
      func = FUNC_CPU_READ;
      if ($urandom_range(0, 1) == 0) addr[15:12] = OUTER_PAGE;
    end else if (pick < 75) begin
      func = FUNC_PRG_XLATE;
    end else begin
      func = FUNC_CHR_XLATE;
      if ($urandom_range(0, 3) != 0) addr[15:13] = 3'b000;
    end
    send_access(func, addr, wdata, 8'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      steady = (p == 3);
      case (p)
        0: set_banks(7, 11, 2);
        1: set_banks(1, 3, 0);
        2: set_banks(7, 11, 3);
        default: set_banks($urandom_range(1, 7), $urandom_range(3, 11), $urandom_range(0, 3));
      endcase

      if (p == 0) begin
        send_access(FUNC_CPU_READ,  16'h5000, 8'h00, 8'hFF);
        send_access(FUNC_CPU_READ,  16'h5FFF, 8'hFF, 8'h00);
        send_access(FUNC_CPU_READ,  16'hFFFF, 8'h00, 8'hA5);
        send_access(FUNC_CPU_READ,  16'h4FFF, 8'h00, 8'h5A);
        send_access(FUNC_PRG_XLATE, 16'h8000, 8'h00, 8'h00);
        send_access(FUNC_PRG_XLATE, 16'hFFFF, 8'h00, 8'h00);
        send_access(FUNC_PRG_XLATE, 16'h0000, 8'h00, 8'h00);
        send_access(FUNC_CHR_XLATE, 16'h0000, 8'h00, 8'h00);
        send_access(FUNC_CHR_XLATE, 16'h1FFF, 8'h00, 8'h00);
        send_access(FUNC_CHR_XLATE, 16'hFFFF, 8'h00, 8'h00);
        send_access(FUNC_CPU_WRITE, MMC3_BANK_SELECT, 8'hC7, 8'h00);
        send_access(FUNC_CPU_WRITE, MMC3_BANK_DATA, 8'hFF, 8'h00);
        send_access(FUNC_PRG_XLATE, 16'hA000, 8'h00, 8'h00);
        send_access(FUNC_CHR_XLATE, 16'h0400, 8'h00, 8'h00);
        send_access(FUNC_CPU_WRITE, outer_addr(OUTER_PRG_REG), 8'h3F, 8'h00);
        send_access(FUNC_CPU_WRITE, outer_addr(OUTER_CHR_REG), 8'hFF, 8'h00);
        send_access(FUNC_CPU_WRITE, outer_addr(OUTER_SPARE_REG), 8'h12, 8'h00);
        send_access(FUNC_CPU_WRITE, outer_addr(OUTER_MODE_REG), 8'h06, 8'h00);
        send_access(FUNC_CPU_WRITE, 16'hA000, 8'h03, 8'h00);
        send_access(FUNC_CHR_XLATE, 16'h1FFF, 8'h00, 8'h00);
        send_access(FUNC_PRG_XLATE, 16'hFFFF, 8'h00, 8'h00);
        send_access(FUNC_CPU_WRITE, outer_addr(OUTER_MODE_REG), 8'h04, 8'h00);
        send_access(FUNC_PRG_XLATE, 16'hC123, 8'h00, 8'h00);
        send_access(FUNC_CPU_WRITE, outer_addr(OUTER_MODE_REG), 8'h05, 8'h00);
        send_access(FUNC_CHR_XLATE, 16'h0C00, 8'h00, 8'h00);
        send_access(FUNC_CPU_WRITE, 16'h6000, 8'h55, 8'h00);
        send_access(FUNC_CPU_WRITE, 16'h4FFF, 8'hAA, 8'h00);
        send_access(FUNC_CPU_WRITE, outer_addr(OUTER_MODE_REG), 8'h00, 8'h00);
      end else begin
        for (int i = 0; i < PHASE_ITEMS; i++) begin
          // lock the outer registers halfway through the last phase
          if (p == PHASES - 1 && i == PHASE_ITEMS / 2)
            send_access(FUNC_CPU_WRITE, outer_addr(OUTER_MODE_REG),
                        {1'b1, 7'($urandom)}, 8'($urandom));
          random_access();
        end
      end
      drain_results();
    end

    if (failures == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
